// File: design/rldr_pkg.sv
package rldr_pkg;

   localparam int COORD_BITS = 12;
   localparam int FRAC_BITS = 8;
   localparam int POS_BITS = COORD_BITS + FRAC_BITS;
   localparam int OFF_W = POS_BITS + 1;
   localparam int SRC_BITS = POS_BITS + 2;

   localparam int Q8_W = COORD_BITS + 9;
   localparam int Q8_SHR = (FRAC_BITS >= 8) ? FRAC_BITS - 8 : 0;
   localparam int Q8_SHL = (FRAC_BITS < 8) ? 8 - FRAC_BITS : 0;
   localparam int SQ_W = 2 * Q8_W;
   localparam int SUM_W = SQ_W;

   localparam int NORM_W = 42;
   localparam int SLICE_W = 14;
   localparam int PROD_W = SUM_W + SLICE_W;
   localparam int ACC_W = PROD_W + 1;
   localparam int R2_SHIFT = 12;
   localparam int R2_W = 21;
   localparam int Q16 = 16;
   localparam int ONE_Q16 = 65536;

   localparam int QUAD_W = 17;
   localparam int RESC_W = 18;
   localparam int BRT_W = 21;
   localparam int GAIN_W = 21;
   localparam int RESCALE_RESET = 65536;

   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 6;

   localparam int REQ_DATA_W = ((2 * COORD_BITS + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = 2 * SRC_BITS + GAIN_W;
   localparam int RSP_DATA_W = ((RSP_FIELDS_W + 7) / 8) * 8;

   typedef enum logic [2:0] {
      REG_CENTRE_X   = 3'd0,
      REG_CENTRE_Y   = 3'd1,
      REG_RADIUS     = 3'd2,
      REG_QUADRATIC  = 3'd3,
      REG_QUARTIC    = 3'd4,
      REG_RESCALE    = 3'd5,
      REG_BRIGHTEN   = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic [POS_BITS-1:0]      centre_x_pos;
      logic [POS_BITS-1:0]      centre_y_pos;
      logic [NORM_W-1:0]        radius_norm;
      logic signed [QUAD_W-1:0] coef_quadratic;
      logic signed [QUAD_W-1:0] coef_quartic;
      logic [RESC_W-1:0]        rescale_gain;
      logic signed [BRT_W-1:0]  brighten_coef;
   } cfg_type;

   typedef struct packed {
      logic signed [OFF_W-1:0] off_x;
      logic signed [OFF_W-1:0] off_y;
      logic [R2_W-1:0]         r2;
   } rad_type;

   typedef struct packed {
      logic signed [GAIN_W-1:0]   light_gain;
      logic signed [SRC_BITS-1:0] src_row;
      logic signed [SRC_BITS-1:0] src_col;
   } res_type;

   // Brings a Q.FRAC_BITS offset to Q.8 with floor rounding.
   function automatic logic signed [Q8_W-1:0] to_q8(input logic signed [OFF_W-1:0] off);
      logic signed [OFF_W+8:0] wide;
      wide = (OFF_W + 9)'(off);
      wide = (wide >>> Q8_SHR) <<< Q8_SHL;
      return wide[Q8_W-1:0];
   endfunction

endpackage

// File: design/rldr_csr.sv
module rldr_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [rldr_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [rldr_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [rldr_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready,
   output rldr_pkg::cfg_type                cfg
);
   import rldr_pkg::*;

   cfg_type       cfg_ff;
   reg_index_type index;
   logic          write_en;

   assign index = reg_index_type'(csr_paddr[CSR_ADDR_W-1:3]);
   assign write_en = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{rescale_gain: RESC_W'(RESCALE_RESET), default: '0};
      end else if (write_en) begin
         case (index)
            REG_CENTRE_X: cfg_ff.centre_x_pos <= csr_pwdata[POS_BITS-1:0];
            REG_CENTRE_Y: cfg_ff.centre_y_pos <= csr_pwdata[POS_BITS-1:0];
            REG_RADIUS: cfg_ff.radius_norm <= csr_pwdata[NORM_W-1:0];
            REG_QUADRATIC: cfg_ff.coef_quadratic <= csr_pwdata[QUAD_W-1:0];
            REG_QUARTIC: cfg_ff.coef_quartic <= csr_pwdata[QUAD_W-1:0];
            REG_RESCALE: cfg_ff.rescale_gain <= csr_pwdata[RESC_W-1:0];
            REG_BRIGHTEN: cfg_ff.brighten_coef <= csr_pwdata[BRT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_CENTRE_X: csr_prdata = CSR_DATA_W'(cfg_ff.centre_x_pos);
         REG_CENTRE_Y: csr_prdata = CSR_DATA_W'(cfg_ff.centre_y_pos);
         REG_RADIUS: csr_prdata = CSR_DATA_W'(cfg_ff.radius_norm);
         REG_QUADRATIC: csr_prdata = CSR_DATA_W'($unsigned(cfg_ff.coef_quadratic));
         REG_QUARTIC: csr_prdata = CSR_DATA_W'($unsigned(cfg_ff.coef_quartic));
         REG_RESCALE: csr_prdata = CSR_DATA_W'(cfg_ff.rescale_gain);
         REG_BRIGHTEN: csr_prdata = CSR_DATA_W'($unsigned(cfg_ff.brighten_coef));
         default: csr_prdata = '0;
      endcase
   end

endmodule

// File: design/rldr_radius.sv
module rldr_radius (
   input  logic                             clock,
   input  logic                             reset,
   input  rldr_pkg::cfg_type                cfg,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  logic [rldr_pkg::COORD_BITS-1:0]  in_col,
   input  logic [rldr_pkg::COORD_BITS-1:0]  in_row,
   output logic                             out_valid,
   input  logic                             out_ready,
   output rldr_pkg::rad_type                out_data
);
   import rldr_pkg::*;

   localparam int STAGES = 5;
   localparam int R2U_W = ACC_W - R2_SHIFT;
   localparam logic [R2_W-1:0] R2_MAX = R2_W'(1) << (R2_W - 1);

   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   logic [STAGES:0]   ready;

   logic signed [OFF_W-1:0] offx_ff [STAGES];
   logic signed [OFF_W-1:0] offy_ff [STAGES];
   logic signed [OFF_W-1:0] offx_in;
   logic signed [OFF_W-1:0] offy_in;

   logic signed [SQ_W-1:0] sqx_in;
   logic signed [SQ_W-1:0] sqy_in;
   logic [SQ_W-2:0]        sqx_ff;
   logic [SQ_W-2:0]        sqy_ff;

   logic [SUM_W-1:0]  sum_in;
   logic [SUM_W-1:0]  sum_ff;

   logic [PROD_W-1:0] prod0_in, prod1_in, prod2_in;
   logic [PROD_W-1:0] prod0_ff, prod1_ff, prod2_ff;

   logic [ACC_W-1:0]  acc1;
   logic [ACC_W-1:0]  acc2;
   logic [R2U_W-1:0]  r2u;
   logic [R2_W-1:0]   r2_in;
   logic [R2_W-1:0]   r2_ff;

   always_comb begin
      ready[STAGES] = out_ready;
      for (int i = STAGES - 1; i >= 0; i--) begin
         ready[i] = !valid_ff[i] || ready[i+1];
      end
      valid_in[0] = in_valid;
      for (int i = 1; i < STAGES; i++) begin
         valid_in[i] = valid_ff[i-1];
      end
   end

   always_comb begin
      offx_in = signed'({1'b0, in_col, {FRAC_BITS{1'b0}}}) - signed'({1'b0, cfg.centre_x_pos});
      offy_in = signed'({1'b0, in_row, {FRAC_BITS{1'b0}}}) - signed'({1'b0, cfg.centre_y_pos});
      sqx_in = to_q8(offx_ff[0]) * to_q8(offx_ff[0]);
      sqy_in = to_q8(offy_ff[0]) * to_q8(offy_ff[0]);
      sum_in = SUM_W'(sqx_ff) + SUM_W'(sqy_ff);
      prod0_in = sum_ff * cfg.radius_norm[SLICE_W-1:0];
      prod1_in = sum_ff * cfg.radius_norm[2*SLICE_W-1:SLICE_W];
      prod2_in = sum_ff * cfg.radius_norm[3*SLICE_W-1:2*SLICE_W];
      acc1 = ACC_W'(prod1_ff) + ACC_W'(prod0_ff >> SLICE_W);
      acc2 = ACC_W'(prod2_ff) + (acc1 >> SLICE_W);
      r2u = acc2[ACC_W-1:R2_SHIFT];
      r2_in = (r2u > R2U_W'(R2_MAX)) ? R2_MAX : r2u[R2_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < STAGES; i++) begin
            if (ready[i]) begin
               valid_ff[i] <= valid_in[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready[0]) begin
         offx_ff[0] <= offx_in;
         offy_ff[0] <= offy_in;
      end
      for (int i = 1; i < STAGES; i++) begin
         if (ready[i]) begin
            offx_ff[i] <= offx_ff[i-1];
            offy_ff[i] <= offy_ff[i-1];
         end
      end
      if (ready[1]) begin
         sqx_ff <= sqx_in[SQ_W-2:0];
         sqy_ff <= sqy_in[SQ_W-2:0];
      end
      if (ready[2]) begin
         sum_ff <= sum_in;
      end
      if (ready[3]) begin
         prod0_ff <= prod0_in;
         prod1_ff <= prod1_in;
         prod2_ff <= prod2_in;
      end
      if (ready[4]) begin
         r2_ff <= r2_in;
      end
   end

   assign in_ready = ready[0];
   assign out_valid = valid_ff[STAGES-1];
   assign out_data = '{off_x: offx_ff[STAGES-1], off_y: offy_ff[STAGES-1], r2: r2_ff};

endmodule

// File: design/rldr_warp.sv
module rldr_warp (
   input  logic               clock,
   input  logic               reset,
   input  rldr_pkg::cfg_type  cfg,
   input  logic               in_valid,
   output logic               in_ready,
   input  rldr_pkg::rad_type  in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output rldr_pkg::res_type  out_data
);
   import rldr_pkg::*;

   localparam int STAGES = 6;
   localparam int OFF_STAGES = 4;
   localparam int R2SQ_W = 2 * R2_W;
   localparam int R2CQ_W = R2_W + 1 + QUAD_W;
   localparam int R4_W = R2SQ_W - Q16;
   localparam int R4CQ_W = R4_W + 1 + QUAD_W;
   localparam int MSUM_W = R4CQ_W + 1;
   localparam int MAG_W = MSUM_W - Q16;
   localparam int ONEP_W = MAG_W + 1;
   localparam int SCL_W = RESC_W + 1 + ONEP_W;
   localparam int BGT_W = MAG_W + BRT_W;
   localparam int BSH_W = BGT_W - Q16;
   localparam int GSUM_W = BSH_W + 1;
   localparam int MULT_W = SCL_W - Q16;
   localparam int PX_W = MULT_W + OFF_W;
   localparam int PXS_W = PX_W - Q16;
   localparam int SX_W = PXS_W + 1;

   localparam logic signed [SX_W-1:0] SX_LO = SX_W'(-(longint'(1) << POS_BITS));
   localparam logic signed [SX_W-1:0] SX_HI = SX_W'((longint'(1) << (POS_BITS + 1)) - 1);
   localparam logic signed [GSUM_W-1:0] G_LO = GSUM_W'(-(longint'(1) << (GAIN_W - 1)));
   localparam logic signed [GSUM_W-1:0] G_HI = GSUM_W'((longint'(1) << (GAIN_W - 1)) - 1);

   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   logic [STAGES:0]   ready;

   logic signed [OFF_W-1:0] offx_ff [OFF_STAGES];
   logic signed [OFF_W-1:0] offy_ff [OFF_STAGES];

   logic [R2SQ_W-1:0]        r2sq_in, r2sq_ff;
   logic signed [R2CQ_W-1:0] r2cq_in, r2cq_ff, r2cq_hold_ff;
   logic [R4_W-1:0]          r4;
   logic signed [R4CQ_W-1:0] r4cq_in, r4cq_ff;
   logic signed [MSUM_W-1:0] msum;
   logic signed [MAG_W-1:0]  mag_in, mag_ff;
   logic signed [ONEP_W-1:0] onep;
   logic signed [SCL_W-1:0]  scl_in, scl_ff;
   logic signed [BGT_W-1:0]  bgt_in, bgt_ff;
   logic signed [MULT_W-1:0] mult;
   logic signed [PX_W-1:0]   px_in, px_ff, py_in, py_ff;
   logic signed [BSH_W-1:0]  bsh;
   logic signed [GSUM_W-1:0] gsum;
   logic signed [GAIN_W-1:0] gain_in, gain_ff, gain_out_ff;
   logic signed [PXS_W-1:0]  pxs, pys;
   logic signed [SX_W-1:0]   sx, sy;
   logic signed [SRC_BITS-1:0] src_col_in, src_row_in, src_col_ff, src_row_ff;

   always_comb begin
      ready[STAGES] = out_ready;
      for (int i = STAGES - 1; i >= 0; i--) begin
         ready[i] = !valid_ff[i] || ready[i+1];
      end
      valid_in[0] = in_valid;
      for (int i = 1; i < STAGES; i++) begin
         valid_in[i] = valid_ff[i-1];
      end
   end

   always_comb begin
      r2sq_in = in_data.r2 * in_data.r2;
      r2cq_in = signed'({1'b0, in_data.r2}) * cfg.coef_quadratic;

      r4 = r2sq_ff[R2SQ_W-1:Q16];
      r4cq_in = signed'({1'b0, r4}) * cfg.coef_quartic;

      msum = MSUM_W'(r2cq_hold_ff) + MSUM_W'(r4cq_ff);
      mag_in = msum[MSUM_W-1:Q16];

      onep = ONEP_W'(mag_ff) + ONEP_W'(ONE_Q16);
      scl_in = signed'({1'b0, cfg.rescale_gain}) * onep;
      bgt_in = mag_ff * cfg.brighten_coef;

      mult = scl_ff[SCL_W-1:Q16];
      px_in = mult * offx_ff[OFF_STAGES-1];
      py_in = mult * offy_ff[OFF_STAGES-1];
      bsh = bgt_ff[BGT_W-1:Q16];
      gsum = GSUM_W'(bsh) + GSUM_W'(ONE_Q16);
      if (gsum < G_LO) begin
         gain_in = G_LO[GAIN_W-1:0];
      end else if (gsum > G_HI) begin
         gain_in = G_HI[GAIN_W-1:0];
      end else begin
         gain_in = gsum[GAIN_W-1:0];
      end

      pxs = px_ff[PX_W-1:Q16];
      pys = py_ff[PX_W-1:Q16];
      sx = SX_W'(signed'({1'b0, cfg.centre_x_pos})) + SX_W'(pxs);
      sy = SX_W'(signed'({1'b0, cfg.centre_y_pos})) + SX_W'(pys);
      if (sx < SX_LO) begin
         src_col_in = SX_LO[SRC_BITS-1:0];
      end else if (sx > SX_HI) begin
         src_col_in = SX_HI[SRC_BITS-1:0];
      end else begin
         src_col_in = sx[SRC_BITS-1:0];
      end
      if (sy < SX_LO) begin
         src_row_in = SX_LO[SRC_BITS-1:0];
      end else if (sy > SX_HI) begin
         src_row_in = SX_HI[SRC_BITS-1:0];
      end else begin
         src_row_in = sy[SRC_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < STAGES; i++) begin
            if (ready[i]) begin
               valid_ff[i] <= valid_in[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready[0]) begin
         offx_ff[0] <= in_data.off_x;
         offy_ff[0] <= in_data.off_y;
         r2sq_ff <= r2sq_in;
         r2cq_ff <= r2cq_in;
      end
      for (int i = 1; i < OFF_STAGES; i++) begin
         if (ready[i]) begin
            offx_ff[i] <= offx_ff[i-1];
            offy_ff[i] <= offy_ff[i-1];
         end
      end
      if (ready[1]) begin
         r4cq_ff <= r4cq_in;
         r2cq_hold_ff <= r2cq_ff;
      end
      if (ready[2]) begin
         mag_ff <= mag_in;
      end
      if (ready[3]) begin
         scl_ff <= scl_in;
         bgt_ff <= bgt_in;
      end
      if (ready[4]) begin
         px_ff <= px_in;
         py_ff <= py_in;
         gain_ff <= gain_in;
      end
      if (ready[5]) begin
         src_col_ff <= src_col_in;
         src_row_ff <= src_row_in;
         gain_out_ff <= gain_ff;
      end
   end

   assign in_ready = ready[0];
   assign out_valid = valid_ff[STAGES-1];
   assign out_data = '{light_gain: gain_out_ff, src_row: src_row_ff, src_col: src_col_ff};

   a_enter: assert property (@(posedge clock) disable iff (reset)
      in_valid && in_ready |=> valid_ff[0])
      else $error("Accepted item did not enter the first stage.");

   a_mid_hold: assert property (@(posedge clock) disable iff (reset)
      valid_ff[2] && !ready[3] |=> valid_ff[2] && $stable(mag_ff))
      else $error("Stalled distortion stage lost or changed its item.");

   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      valid_ff[STAGES-1] && !out_ready |=> valid_ff[STAGES-1] && $stable(src_col_ff)
         && $stable(src_row_ff) && $stable(gain_out_ff))
      else $error("Stalled result changed before its transfer.");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !valid_ff[STAGES-1] |-> in_ready)
      else $error("Stage chain refused an item while the output stage was empty.");

endmodule

// File: design/radial_lens_distortion_remap_unit.sv
// Throughput is one transfer per cycle through eleven registered stages while the response is not stalled.
// A response stall holds only the stages that are full, and empty stages keep filling.
// Reset clears every stage valid bit and loads the register reset values.
// The rescale gain resets to one and all other registers reset to zero.
module radial_lens_distortion_remap_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // Fields from bit 0: dest_col, dest_row.
   input  logic [rldr_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // Fields from bit 0: src_col, src_row, light_gain, zero padding.
   output logic [rldr_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [rldr_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [rldr_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [rldr_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);
   import rldr_pkg::*;

   cfg_type cfg;
   rad_type rad_data;
   res_type res_data;
   logic    rad_valid;
   logic    rad_ready;

   rldr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   rldr_radius u_radius (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_col    (req_tdata[COORD_BITS-1:0]),
      .in_row    (req_tdata[2*COORD_BITS-1:COORD_BITS]),
      .out_valid (rad_valid),
      .out_ready (rad_ready),
      .out_data  (rad_data)
   );

   rldr_warp u_warp (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (rad_valid),
      .in_ready  (rad_ready),
      .in_data   (rad_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (res_data)
   );

   assign rsp_tdata = RSP_DATA_W'({res_data.light_gain, res_data.src_row, res_data.src_col});

endmodule
